FILE: sv/tfd_pkg.sv
// Shared types and constants for the TPKT frame delineator.
package tfd_pkg;

   localparam logic [7:0]  TPKT_START        = 8'h03;
   localparam logic [7:0]  TPKT_RESERVED     = 8'h00;
   localparam logic [15:0] TPKT_HEADER_BYTES = 16'd4;
   localparam logic [15:0] MAX_LEN_RESET     = 16'd8192;

   typedef enum logic [1:0] {
      KIND_DISCARD = 2'd0,
      KIND_HEADER  = 2'd1,
      KIND_PAYLOAD = 2'd2,
      KIND_LAST    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_START   = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0]  byte_out;
      kind_type    byte_kind;
      logic        frame_error;
      logic [15:0] frame_length;
   } result_type;

endpackage

FILE: sv/tfd_engine.sv
// Framing state machine: tags each accepted byte and tracks the frame position.
module tfd_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         byte_value,
   input  logic [15:0]        max_frame_length,
   output tfd_pkg::result_type result
);
   import tfd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        hunting_ff, hunting_in;
   logic [1:0]  header_pos_ff, header_pos_in;
   logic [15:0] length_seen_ff, length_seen_in;
   logic [15:0] bytes_left_ff, bytes_left_in;

   logic [15:0] len_full;
   logic        len_bad;
   logic        len_min;

   assign len_full = {length_seen_ff[15:8], byte_value};
   assign len_bad  = (len_full < TPKT_HEADER_BYTES) || (len_full > max_frame_length);
   assign len_min  = (len_full == TPKT_HEADER_BYTES);

   // Next state.
   always_comb begin
      phase_in       = phase_ff;
      hunting_in     = hunting_ff;
      header_pos_in  = header_pos_ff;
      length_seen_in = length_seen_ff;
      bytes_left_in  = bytes_left_ff;
      if (hunting_ff) begin
         if (header_pos_ff == 2'd1 && byte_value == TPKT_RESERVED) begin
            hunting_in    = 1'b0;
            phase_in      = PH_HEADER;
            header_pos_in = 2'd2;
         end else if (byte_value == TPKT_START) begin
            header_pos_in = 2'd1;
         end else begin
            header_pos_in = 2'd0;
         end
      end else begin
         case (phase_ff)
            PH_HEADER: begin
               if (header_pos_ff == 2'd2) begin
                  length_seen_in = {byte_value, 8'h00};
                  header_pos_in  = 2'd3;
               end else if (header_pos_ff == 2'd3) begin
                  length_seen_in = len_full;
                  header_pos_in  = 2'd0;
                  if (len_bad) begin
                     hunting_in = 1'b1;
                     phase_in   = PH_START;
                  end else if (len_min) begin
                     phase_in = PH_START;
                  end else begin
                     bytes_left_in = len_full - TPKT_HEADER_BYTES;
                     phase_in      = PH_PAYLOAD;
                  end
               end else begin
                  header_pos_in = 2'd2;
               end
            end
            PH_PAYLOAD: begin
               if (bytes_left_ff <= 16'd1) begin
                  bytes_left_in = '0;
                  phase_in      = PH_START;
                  header_pos_in = 2'd0;
               end else begin
                  bytes_left_in = bytes_left_ff - 16'd1;
               end
            end
            default: begin
               if (byte_value == TPKT_START) begin
                  phase_in      = PH_HEADER;
                  header_pos_in = 2'd1;
               end else begin
                  hunting_in    = 1'b1;
                  phase_in      = PH_START;
                  header_pos_in = 2'd0;
               end
            end
         endcase
      end
   end

   // Result tagging for the current byte.
   always_comb begin
      result.byte_out     = byte_value;
      result.byte_kind    = KIND_DISCARD;
      result.frame_error  = 1'b0;
      result.frame_length = '0;
      if (hunting_ff) begin
         if ((header_pos_ff == 2'd1 && byte_value == TPKT_RESERVED)
             || byte_value == TPKT_START) begin
            result.byte_kind = KIND_HEADER;
         end
      end else begin
         case (phase_ff)
            PH_HEADER: begin
               result.byte_kind = KIND_HEADER;
               if (header_pos_ff == 2'd3) begin
                  if (len_bad) begin
                     result.frame_error = 1'b1;
                  end else if (len_min) begin
                     result.byte_kind    = KIND_LAST;
                     result.frame_length = len_full;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (bytes_left_ff <= 16'd1) begin
                  result.byte_kind    = KIND_LAST;
                  result.frame_length = length_seen_ff;
               end else begin
                  result.byte_kind = KIND_PAYLOAD;
               end
            end
            default: begin
               if (byte_value == TPKT_START) begin
                  result.byte_kind = KIND_HEADER;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_START;
         hunting_ff     <= 1'b0;
         header_pos_ff  <= 2'd0;
         length_seen_ff <= '0;
         bytes_left_ff  <= '0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         hunting_ff     <= hunting_in;
         header_pos_ff  <= header_pos_in;
         length_seen_ff <= length_seen_in;
         bytes_left_ff  <= bytes_left_in;
      end
   end

   a_error_on_header: assert property (@(posedge clock) disable iff (reset)
      accept && result.frame_error |-> result.byte_kind == KIND_HEADER)
      else $error("frame error reported on a byte that is not a header byte");

   a_length_on_last: assert property (@(posedge clock) disable iff (reset)
      accept |-> ((result.byte_kind == KIND_LAST) == (result.frame_length != 16'd0)))
      else $error("frame length does not match the last-byte tag");

   a_hunt_in_start: assert property (@(posedge clock) disable iff (reset)
      hunting_ff |-> phase_ff == PH_START)
      else $error("hunting outside the start phase");

   a_left_in_payload: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_PAYLOAD |-> bytes_left_ff == 16'd0)
      else $error("payload count left over outside the payload phase");

endmodule

FILE: sv/tpkt_frame_delineator.sv
// Top level of the TPKT frame delineator with its result register and control register.
//
// Usage: one byte of a transport stream enters per request on the req_ channel
// (req_valid, req_stall, req_byte_value). Each byte yields exactly one response on
// the rsp_ channel: the byte itself, its kind (discarded, header, payload or last
// byte of a frame), a frame error flag on the length byte that carried an invalid
// length, and the total frame length on the last byte of a frame.
// The response is registered: rsp_valid rises in the cycle after a byte is accepted.
// One byte is accepted per cycle while req_stall is low; the framing update is a single
// pass from the accepted byte into the response register.
// While a response waits and rsp_stall is high, req_stall is raised and the
// framing state holds. When the waiting response is taken in the same cycle, a
// new request is accepted in that cycle.
// csr_write_enable and csr_write_data set the largest accepted frame length; write
// it only while no request is in flight. Reset (synchronous) restores 8192, puts the
// framer in sync waiting for a start byte and empties the response register.
module tpkt_frame_delineator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_byte_out,
   output logic [1:0]  rsp_byte_kind,
   output logic        rsp_frame_error,
   output logic [15:0] rsp_frame_length,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import tfd_pkg::*;

   logic        accept;
   logic        rsp_valid_ff;
   result_type  rsp_ff;
   result_type  result;
   logic [15:0] max_len_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   tfd_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .byte_value       (req_byte_value),
      .max_frame_length (max_len_ff),
      .result           (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_write_enable) begin
         max_len_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_out     = rsp_ff.byte_out;
   assign rsp_byte_kind    = rsp_ff.byte_kind;
   assign rsp_frame_error  = rsp_ff.frame_error;
   assign rsp_frame_length = rsp_ff.frame_length;

endmodule

FILE: sim/tpkt_frame_delineator_test.sv
// Self-checking testbench for the TPKT frame delineator: queued byte stream, predictor, checker.
module tpkt_frame_delineator_test;
   import tfd_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_NONE   = 0;
   localparam int IDLE_SHORT  = 1;
   localparam int IDLE_FULL   = 2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_value = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_byte_out;
   logic [1:0]  rsp_byte_kind;
   logic        rsp_frame_error;
   logic [15:0] rsp_frame_length;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = 16'h0000;

   // Framer state as the predictor sees it.
   phase_type   fr_phase;
   logic        fr_hunting;
   logic [1:0]  fr_pos;
   logic [15:0] fr_length;
   logic [15:0] fr_left;
   logic [15:0] length_limit = MAX_LEN_RESET;

   logic [7:0]  pending_bytes[$];
   result_type  expected_tags[$];
   result_type  got_tag, want_tag;
   int          queued_count = 0;
   int          accepted_count = 0;
   int          fail_count = 0;
   int          cycle_count = 0;
   int          idle_mode = IDLE_FULL;
   int          gap_left = 0;
   int          stall_left = 0;
   int          hold_left = 0;
   bit          hold_toggle = 1'b0;
   bit          hold_seen = 1'b0;

   tpkt_frame_delineator DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_value   (req_byte_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_byte_kind    (rsp_byte_kind),
      .rsp_frame_error  (rsp_frame_error),
      .rsp_frame_length (rsp_frame_length),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (idle_mode == IDLE_NONE || r < 65) return 0;
      if (r < 93 || idle_mode == IDLE_SHORT) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Tags one accepted byte and advances the predicted framer state.
   function automatic result_type tag_byte(input logic [7:0] b);
      result_type  r;
      logic [15:0] len;
      r.byte_out     = b;
      r.byte_kind    = KIND_DISCARD;
      r.frame_error  = 1'b0;
      r.frame_length = 16'h0000;
      if (fr_hunting) begin
         if (fr_pos == 2'd1 && b == TPKT_RESERVED) begin
            r.byte_kind = KIND_HEADER;
            fr_hunting  = 1'b0;
            fr_phase    = PH_HEADER;
            fr_pos      = 2'd2;
         end else if (b == TPKT_START) begin
            r.byte_kind = KIND_HEADER;
            fr_pos      = 2'd1;
         end else begin
            fr_pos = 2'd0;
         end
      end else if (fr_phase == PH_HEADER) begin
         r.byte_kind = KIND_HEADER;
         if (fr_pos == 2'd2) begin
            fr_length = {b, 8'h00};
            fr_pos    = 2'd3;
         end else if (fr_pos == 2'd3) begin
            len       = fr_length | {8'h00, b};
            fr_length = len;
            if (len < TPKT_HEADER_BYTES || len > length_limit) begin
               r.frame_error = 1'b1;
               fr_hunting    = 1'b1;
               fr_phase      = PH_START;
               fr_pos        = 2'd0;
            end else if (len == TPKT_HEADER_BYTES) begin
               r.byte_kind    = KIND_LAST;
               r.frame_length = len;
               fr_phase       = PH_START;
               fr_pos         = 2'd0;
            end else begin
               fr_left  = len - TPKT_HEADER_BYTES;
               fr_phase = PH_PAYLOAD;
               fr_pos   = 2'd0;
            end
         end else begin
            fr_pos = 2'd2;
         end
      end else if (fr_phase == PH_PAYLOAD) begin
         if (fr_left <= 16'd1) begin
            fr_left        = 16'd0;
            r.byte_kind    = KIND_LAST;
            r.frame_length = fr_length;
            fr_phase       = PH_START;
            fr_pos         = 2'd0;
         end else begin
            fr_left     = fr_left - 16'd1;
            r.byte_kind = KIND_PAYLOAD;
         end
      end else begin
         if (b == TPKT_START) begin
            r.byte_kind = KIND_HEADER;
            fr_phase    = PH_HEADER;
            fr_pos      = 2'd1;
         end else begin
            fr_hunting = 1'b1;
            fr_phase   = PH_START;
            fr_pos     = 2'd0;
         end
      end
      return r;
   endfunction

   // Request driver: one byte per request, a random gap after each one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_valid      <= 1'b1;
            req_byte_value <= pending_bytes.pop_front();
            gap_left = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side stall, with an occasional long hold-off on request.
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_seen != hold_toggle) begin
         hold_seen = hold_toggle;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         n = pick_gap();
         rsp_stall <= (n != 0);
         stall_left = (n > 0) ? n - 1 : 0;
      end
   end

   // Checks responses first: a request taken at this edge cannot answer at it.
   always @(posedge clock) begin
      if (reset) begin
         fr_phase   = PH_START;
         fr_hunting = 1'b0;
         fr_pos     = 2'd0;
         fr_length  = 16'h0000;
         fr_left    = 16'h0000;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_tag.byte_out     = rsp_byte_out;
            got_tag.byte_kind    = kind_type'(rsp_byte_kind);
            got_tag.frame_error  = rsp_frame_error;
            got_tag.frame_length = rsp_frame_length;
            if (expected_tags.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response: byte %02h kind %0d err %0b len %0d",
                           got_tag.byte_out, got_tag.byte_kind, got_tag.frame_error,
                           got_tag.frame_length);
            end else begin
               want_tag = expected_tags.pop_front();
               if (got_tag !== want_tag) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected byte %02h kind %0d err %0b len %0d,",
                              want_tag.byte_out, want_tag.byte_kind, want_tag.frame_error,
                              want_tag.frame_length,
                              " got byte %02h kind %0d err %0b len %0d",
                              got_tag.byte_out, got_tag.byte_kind,
                              got_tag.frame_error, got_tag.frame_length);
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_tags.push_back(tag_byte(req_byte_value));
            accepted_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic queue_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      queued_count++;
   endtask

   // A frame header; the payload follows only when the length will be accepted.
   task automatic queue_frame(input logic [15:0] len, input logic [7:0] reserved);
      queue_byte(TPKT_START);
      queue_byte(reserved);
      queue_byte(len[15:8]);
      queue_byte(len[7:0]);
      if (len >= TPKT_HEADER_BYTES && len <= length_limit)
         repeat (len - TPKT_HEADER_BYTES) queue_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic queue_traffic(input int n_bytes);
      int          first, r, cap, over;
      logic [15:0] len;
      logic [7:0]  reserved;
      first = queued_count;
      while (queued_count - first < n_bytes) begin
         r   = $urandom_range(0, 99);
         cap = (length_limit >= 4 && length_limit < 24) ? int'(length_limit) : 24;
         reserved = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : TPKT_RESERVED;
         if (r < 65) begin
            len = 16'($urandom_range(4, cap));
         end else if (r < 72) begin
            if (length_limit < 4) len = 16'd4;
            else if (length_limit < 300) len = length_limit;
            else len = 16'($urandom_range(25, 300));
         end else if (r < 82) begin
            if (length_limit == 16'hFFFF || $urandom_range(0, 1) == 0) begin
               len = 16'($urandom_range(0, 3));
            end else begin
               over = int'(length_limit) + int'($urandom_range(1, 40));
               len  = (over > 65535) ? 16'hFFFF : 16'(over);
            end
         end else if (r < 92) begin
            repeat ($urandom_range(1, 6)) queue_byte(8'($urandom_range(0, 255)));
         end else begin
            // Broken start: a start byte followed by a nonzero second byte.
            queue_byte(TPKT_START);
            queue_byte(8'($urandom_range(1, 255)));
         end
         if (r < 82) queue_frame(len, reserved);
      end
   endtask

   task automatic wait_drained();
      while (accepted_count != queued_count || expected_tags.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_length_limit(input logic [15:0] value);
      wait_drained();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      length_limit = value;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Shortest frame, then a frame with a nonzero reserved byte.
      queue_frame(16'd4, TPKT_RESERVED);
      queue_frame(16'd5, 8'hFF);
      // Lost start, an abandoned candidate, a renewed candidate, then resync.
      queue_byte(8'h55);
      queue_byte(TPKT_START);
      queue_byte(8'h07);
      queue_byte(TPKT_START);
      queue_byte(TPKT_START);
      queue_byte(TPKT_RESERVED);
      queue_byte(8'h00);
      queue_byte(8'h06);
      queue_byte(8'h11);
      queue_byte(8'h22);
      // Too short, then too long while hunting, then a good frame.
      queue_frame(16'd3, TPKT_RESERVED);
      queue_frame(16'hFFFF, TPKT_RESERVED);
      queue_frame(16'd4, TPKT_RESERVED);
      wait_drained();

      // Long receiver hold-off while requests keep coming.
      hold_toggle = ~hold_toggle;
      queue_traffic(200);

      write_length_limit(16'd4);
      queue_traffic(60);

      write_length_limit(16'hFFFF);
      idle_mode = IDLE_NONE;
      queue_frame(16'd40, TPKT_RESERVED);
      wait_drained();
      idle_mode = IDLE_FULL;
      queue_traffic(80);

      // A limit below the header size rejects every frame.
      write_length_limit(16'd3);
      queue_frame(16'd4, TPKT_RESERVED);
      queue_traffic(30);

      write_length_limit(16'($urandom_range(5, 40)));
      queue_traffic(140);
      wait_drained();

      fail_count += expected_tags.size();
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
